// ===== design/cst_pkg.sv =====
// Shared definitions for the counting semaphore table.
// Holds the request and status codes and the parameter defaults; no dependencies.
package cst_pkg;

  localparam int SEM_COUNT_DEF   = 64;
  localparam int COUNT_WIDTH_DEF = 15;

  localparam logic [1:0] ACT_CREATE = 2'd0;
  localparam logic [1:0] ACT_WAIT   = 2'd1;
  localparam logic [1:0] ACT_POST   = 2'd2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_ID      = 3'd1,
    ST_NO_FREE     = 3'd2,
    ST_NEG_INIT    = 3'd3,
    ST_WOULD_BLOCK = 3'd4,
    ST_FULL        = 3'd5
  } status_t;

endpackage

// ===== design/cst_count_ram.sv =====
// Count store of the counting semaphore table: one write port, one read port.
// Read data is registered. Depends on cst_pkg.
module cst_count_ram #(
  parameter int DEPTH = cst_pkg::SEM_COUNT_DEF,
  parameter int WIDTH = cst_pkg::COUNT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/counting_semaphore_table.sv =====
// Counting semaphore table: S_IDLE accepts a request and reads the entry's count from the
// count memory; S_READ decides, writes back and loads the result register, and holds while
// that register is occupied. The next request is taken in the cycle after the previous result
// is loaded, so no new request is taken before the last one is done. Entries are allocated in
// order and never freed, so a fill counter marks the entries in use; no clearing pass is
// needed after reset. Depends on cst_pkg and cst_count_ram.
module counting_semaphore_table #(
  parameter int SEM_COUNT   = cst_pkg::SEM_COUNT_DEF,
  parameter int COUNT_WIDTH = cst_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [5:0]  sem_id,
  input  logic signed [15:0] init_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [5:0]  result_id,
  output logic        wake,
  output logic [14:0] count_after
);
  import cst_pkg::*;

  localparam int ADDR_W = $clog2(SEM_COUNT);
  localparam int FILL_W = $clog2(SEM_COUNT + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t           state;
  logic [1:0]       req_action;
  logic [5:0]       req_id;
  logic [15:0]      req_value;
  logic [FILL_W-1:0] fill;

  logic [31:0]      in_id_ext;
  logic [31:0]      req_id_ext;
  logic [31:0]      fill_ext;
  logic [31:0]      value_ext;
  logic [31:0]      max_ext;
  logic [31:0]      sat_ext;
  logic [31:0]      cnt_ext;
  logic             id_valid;
  logic             table_full;
  logic             do_finish;

  logic [COUNT_WIDTH-1:0] rd_data;
  logic             dec_wr;
  logic [ADDR_W-1:0] dec_addr;
  logic [COUNT_WIDTH-1:0] dec_data;
  logic             fill_inc;
  status_t          dec_status;
  logic [5:0]       dec_id;
  logic             dec_wake;
  logic [COUNT_WIDTH-1:0] dec_count;

  assign in_ready   = (state == S_IDLE);
  assign do_finish  = (state == S_READ) && (!out_valid || out_ready);
  assign in_id_ext  = {26'b0, sem_id};
  assign req_id_ext = {26'b0, req_id};
  assign fill_ext   = {{(32-FILL_W){1'b0}}, fill};
  assign value_ext  = {17'b0, req_value[14:0]};
  assign max_ext    = {{(32-COUNT_WIDTH){1'b0}}, COUNT_MAX};
  assign sat_ext    = (value_ext > max_ext) ? max_ext : value_ext;
  assign cnt_ext    = {{(32-COUNT_WIDTH){1'b0}}, dec_count};
  assign id_valid   = (req_id_ext < 32'(SEM_COUNT)) && (req_id_ext < fill_ext);
  assign table_full = (fill == FILL_W'(SEM_COUNT));

  cst_count_ram #(
    .DEPTH(SEM_COUNT),
    .WIDTH(COUNT_WIDTH)
  ) u_ram (
    .clk    (clk),
    .rd_en  (in_valid && in_ready),
    .rd_addr(in_id_ext[ADDR_W-1:0]),
    .rd_data(rd_data),
    .wr_en  (dec_wr && do_finish),
    .wr_addr(dec_addr),
    .wr_data(dec_data)
  );

  always_comb begin
    dec_status = ST_BAD_ID;
    dec_id     = req_id;
    dec_wake   = 1'b0;
    dec_count  = '0;
    dec_wr     = 1'b0;
    dec_addr   = req_id_ext[ADDR_W-1:0];
    dec_data   = '0;
    fill_inc   = 1'b0;
    case (req_action)
      ACT_CREATE: begin
        dec_id = 6'd0;
        if (req_value[15]) begin
          dec_status = ST_NEG_INIT;
        end else if (table_full) begin
          dec_status = ST_NO_FREE;
        end else begin
          dec_status = ST_OK;
          dec_id     = fill_ext[5:0];
          dec_count  = sat_ext[COUNT_WIDTH-1:0];
          dec_wr     = 1'b1;
          dec_addr   = fill_ext[ADDR_W-1:0];
          dec_data   = sat_ext[COUNT_WIDTH-1:0];
          fill_inc   = 1'b1;
        end
      end
      ACT_WAIT: begin
        if (id_valid) begin
          if (rd_data == '0) begin
            dec_status = ST_WOULD_BLOCK;
          end else begin
            dec_status = ST_OK;
            dec_count  = rd_data - 1'b1;
            dec_wr     = 1'b1;
            dec_data   = rd_data - 1'b1;
          end
        end
      end
      ACT_POST: begin
        if (id_valid) begin
          if (rd_data == COUNT_MAX) begin
            dec_status = ST_FULL;
            dec_count  = rd_data;
          end else begin
            dec_status = ST_OK;
            dec_wake   = 1'b1;
            dec_count  = rd_data + 1'b1;
            dec_wr     = 1'b1;
            dec_data   = rd_data + 1'b1;
          end
        end
      end
      default: begin
        dec_status = ST_BAD_ID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !do_finish) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_action <= action;
            req_id     <= sem_id;
            req_value  <= init_value;
            state      <= S_READ;
          end
        end
        S_READ: begin
          if (do_finish) begin
            out_valid   <= 1'b1;
            status      <= dec_status;
            result_id   <= dec_id;
            wake        <= dec_wake;
            count_after <= cnt_ext[14:0];
            if (fill_inc) begin
              fill <= fill + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_ext <= 32'(SEM_COUNT))
    else $error("Fill count exceeds the table size.");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_READ)
    else $error("Accepted request did not enter the read cycle.");

  a_interlock: assert property (@(posedge clk) disable iff (rst)
    state == S_READ && out_valid && !out_ready |=> state == S_READ && $stable(fill))
    else $error("Request completed while the result register was occupied.");

  a_fill_only_create: assert property (@(posedge clk) disable iff (rst)
    !(do_finish && fill_inc) |=> $stable(fill))
    else $error("Fill count moved without a successful create.");

  a_wake_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && wake |-> status == ST_OK)
    else $error("Wake raised on a refused request.");
`endif

endmodule
